FILE: design/ple_pkg.sv
`default_nettype none
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_RETRIEVE = 2'd2,
		OP_APPEND   = 2'd3
	} opcode_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/ple_req_if.sv
`default_nettype none
interface ple_req_if
	import ple_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, opcode, position, new_value, input ready);
	modport sink (input valid, opcode, position, new_value, output ready);
endinterface
`default_nettype wire

FILE: design/ple_rsp_if.sv
`default_nettype none
interface ple_rsp_if
	import ple_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;

	modport source (output valid, ok, read_value, entry_count, input ready);
	modport sink (input valid, ok, read_value, entry_count, output ready);
endinterface
`default_nettype wire

FILE: design/positional_list_engine.sv
// positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values held in a row of cells, one entry per cell.
// req channel: opcode (insert, remove, retrieve, append), 1-based position
// and new_value. rsp channel: ok, read_value and entry_count after the beat.
// every req beat gives exactly one rsp beat.
// insert and remove move all later entries by one place at once,
// since each cell loads from its left or right neighbor in parallel.
// the rsp beat is registered and is valid in the cycle after the req beat is taken.
// throughput: one request per cycle while rsp is taken every cycle; the
// single output register sets this figure.
// when rsp stalls, req.ready stays low until the waiting rsp beat is taken;
// the list is not touched meanwhile.
// reset (arst_n low) empties the list and drops any pending rsp beat; no
// clearing pass is needed, entries beyond the count are never read.
`default_nettype none
module positional_list_engine
	import ple_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ple_req_if.sink     req,
	ple_rsp_if.source   rsp
);

	logic [CNT_W-1:0]  cnt_q;
	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [DATA_W-1:0] rsp_val_q;
	logic [CNT_W-1:0]  rsp_cnt_q;

	logic              take;
	logic [CMP_W-1:0]  pos_e;
	logic [CMP_W-1:0]  cnt_e;
	logic              full;
	logic              pos_nz;
	logic              ok;
	logic              do_ins;
	logic              do_rem;
	logic [CNT_W-1:0]  cnt_next;
	logic [DATA_W-1:0] rd_val;
	cell_cmd_t         cmd;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	assign pos_e  = CMP_W'(req.position);
	assign cnt_e  = CMP_W'(cnt_q);
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign pos_nz = (req.position != '0);

	always_comb begin
		ok     = 1'b0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		cmd.idx = IDX_W'(pos_e - CMP_W'(1));
		case (opcode_t'(req.opcode))
			OP_INSERT: begin
				ok     = pos_nz && (pos_e <= cnt_e + CMP_W'(1)) && !full;
				do_ins = ok;
			end
			OP_REMOVE: begin
				ok     = pos_nz && (pos_e <= cnt_e);
				do_rem = ok;
			end
			OP_RETRIEVE: begin
				ok = pos_nz && (pos_e <= cnt_e);
			end
			OP_APPEND: begin
				ok      = !full;
				do_ins  = ok;
				cmd.idx = IDX_W'(cnt_q);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		cmd.ins   = take && do_ins;
		cmd.rem   = take && do_rem;
		cmd.value = req.new_value;
	end

	always_comb begin
		if (do_ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (do_rem) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		ple_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_idx   (IDX_W'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_val = rd_val | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_ok_q  <= ok;
			rsp_cnt_q <= cnt_next;
			rsp_val_q <= (ok && (opcode_t'(req.opcode) == OP_RETRIEVE)) ? rd_val : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.read_value  = rsp_val_q;
	assign rsp.entry_count = rsp_cnt_q;

endmodule
`default_nettype wire

FILE: design/ple_cell.sv
`default_nettype none
module ple_cell
	import ple_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [IDX_W-1:0]  cell_idx,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0]      data,
	output logic [DATA_W-1:0]      tap
);

	logic [DATA_W-1:0] data_q;
	logic              at_idx;
	logic              past_idx;

	assign at_idx   = (cell_idx == cmd.idx);
	assign past_idx = (cell_idx > cmd.idx);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_idx) begin
				data_q <= cmd.value;
			end else if (past_idx) begin
				data_q <= left_data;
			end
		end else if (cmd.rem && (at_idx || past_idx)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	// masked read so the row can be or-ed together
	assign tap  = at_idx ? data_q : '0;

endmodule
`default_nettype wire
